FILE: sv/skvt_pkg.sv
package skvt_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_WRITE  = 2'd1,
        OP_DELETE = 2'd2,
        OP_SPARE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_RESERVED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINAL,
        S_DONE
    } t_state;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int POS_W = 7;

endpackage

FILE: sv/skvt_mem.sv
module skvt_mem #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [skvt_pkg::KEY_W-1:0] i_wkey,
    input  logic [skvt_pkg::VAL_W-1:0] i_wval,
    input  logic [AW-1:0]              i_raddr,
    output logic [skvt_pkg::KEY_W-1:0] o_rkey,
    output logic [skvt_pkg::VAL_W-1:0] o_rval
);

    logic [skvt_pkg::KEY_W+skvt_pkg::VAL_W-1:0] r_mem [ENTRIES];
    logic [skvt_pkg::KEY_W+skvt_pkg::VAL_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wkey, i_wval};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rkey = r_rd[skvt_pkg::KEY_W+skvt_pkg::VAL_W-1:skvt_pkg::VAL_W];
    assign o_rval = r_rd[skvt_pkg::VAL_W-1:0];

endmodule

FILE: sv/sorted_key_value_table.sv
// Sorted key/value table: up to ENTRIES signed keys with values, held in one
// single-port-read memory in ascending key order. Raise start while busy is
// low to issue a lookup, write or delete; the block answers once with
// o_valid high for one cycle, and the answer cannot be held back, so take it
// when it comes. Each binary search probe reads the memory in S_PROBE and
// compares in S_CMP (at most log2(count)+1 probes, and an absent key ends
// in one more S_PROBE); then come S_DECIDE, a S_SHIFT_RD and S_SHIFT_WR pair
// per entry moved by an insert or delete, and S_FINAL and S_DONE before the
// answer; the memory's one read port sets this. No clearing pass.
module sorted_key_value_table #(
    parameter int ENTRIES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_opcode,
    input  logic signed [skvt_pkg::KEY_W-1:0] i_key,
    input  logic signed [skvt_pkg::VAL_W-1:0] i_value_in,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic signed [skvt_pkg::VAL_W-1:0] o_value_out,
    output logic [skvt_pkg::POS_W-1:0]        o_position,
    output logic [skvt_pkg::POS_W-1:0]        o_entry_count
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    // search bounds carry one extra bit so hi can go to -1
    localparam int BW = CW + 1;
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    skvt_pkg::t_state r_state, n_state;
    logic [1:0]                   r_op;
    logic signed [skvt_pkg::KEY_W-1:0] r_key;
    logic signed [skvt_pkg::VAL_W-1:0] r_val;
    logic [CW-1:0]                r_count, n_count;
    logic signed [BW-1:0]         r_lo, r_hi, n_lo, n_hi;
    logic [CW-1:0]                r_mid;
    logic                         r_found, n_found;
    logic [CW-1:0]                r_pos, n_pos;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_out_v;
    logic [1:0]                   r_out_st, n_out_st;
    logic [skvt_pkg::VAL_W-1:0]   r_out_val, n_out_val;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [skvt_pkg::KEY_W-1:0]   mem_wkey, mem_rkey;
    logic [skvt_pkg::VAL_W-1:0]   mem_wval, mem_rval;
    logic [CW-1:0]                mid_c;
    logic signed [BW:0]           mid_sum;

    skvt_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wkey (mem_wkey),
        .i_wval (mem_wval),
        .i_raddr(mem_raddr),
        .o_rkey (mem_rkey),
        .o_rval (mem_rval)
    );

    assign mid_sum = (BW+1)'(r_lo) + (BW+1)'(r_hi);
    assign mid_c   = CW'(mid_sum >>> 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            skvt_pkg::S_IDLE: begin
                if (start) n_state = skvt_pkg::S_PROBE;
            end
            skvt_pkg::S_PROBE: begin
                if (r_lo <= r_hi) n_state = skvt_pkg::S_CMP;
                else n_state = skvt_pkg::S_DECIDE;
            end
            skvt_pkg::S_CMP: begin
                if (r_key == $signed(mem_rkey)) n_state = skvt_pkg::S_DECIDE;
                else n_state = skvt_pkg::S_PROBE;
            end
            skvt_pkg::S_DECIDE: begin
                if (r_op == skvt_pkg::OP_WRITE && !r_found && r_count < FULL
                        && r_count > r_pos) begin
                    n_state = skvt_pkg::S_SHIFT_RD;
                end else if (r_op == skvt_pkg::OP_DELETE && r_found
                        && r_pos + 1'b1 < r_count) begin
                    n_state = skvt_pkg::S_SHIFT_RD;
                end else begin
                    n_state = skvt_pkg::S_FINAL;
                end
            end
            skvt_pkg::S_SHIFT_RD: n_state = skvt_pkg::S_SHIFT_WR;
            skvt_pkg::S_SHIFT_WR: begin
                if (r_op == skvt_pkg::OP_WRITE) begin
                    if (r_idx - 1'b1 <= r_pos) n_state = skvt_pkg::S_FINAL;
                    else n_state = skvt_pkg::S_SHIFT_RD;
                end else begin
                    if (r_idx + 2'd2 >= r_count) n_state = skvt_pkg::S_FINAL;
                    else n_state = skvt_pkg::S_SHIFT_RD;
                end
            end
            skvt_pkg::S_FINAL: n_state = skvt_pkg::S_DONE;
            skvt_pkg::S_DONE:  n_state = skvt_pkg::S_IDLE;
            default: n_state = skvt_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_found   = r_found;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_count   = r_count;
        n_out_st  = r_out_st;
        n_out_val = r_out_val;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_idx);
        mem_wkey  = mem_rkey;
        mem_wval  = mem_rval;
        mem_raddr = AW'(r_mid);
        case (r_state)
            skvt_pkg::S_IDLE: begin
                n_lo    = '0;
                n_hi    = BW'(r_count) - 1'b1;
                n_found = 1'b0;
            end
            skvt_pkg::S_PROBE: begin
                mem_raddr = AW'(mid_c);
                n_pos     = CW'(r_lo);
            end
            skvt_pkg::S_CMP: begin
                if (r_key > $signed(mem_rkey)) begin
                    n_lo  = BW'(r_mid) + 1'b1;
                    n_pos = r_mid + 1'b1;
                end else if (r_key < $signed(mem_rkey)) begin
                    n_hi  = BW'(r_mid) - 1'b1;
                end else begin
                    n_found = 1'b1;
                    n_pos   = r_mid;
                end
            end
            skvt_pkg::S_DECIDE: begin
                n_out_val = '0;
                n_out_st  = skvt_pkg::ST_OK;
                if (r_op == skvt_pkg::OP_WRITE) begin
                    if (!r_found && (r_count >= FULL || r_pos > r_count))
                        n_out_st = skvt_pkg::ST_FULL;
                    n_idx = r_count;
                end else begin
                    if (!r_found) n_out_st = skvt_pkg::ST_ABSENT;
                    n_idx = r_pos;
                end
            end
            skvt_pkg::S_SHIFT_RD: begin
                if (r_op == skvt_pkg::OP_WRITE) mem_raddr = AW'(r_idx - 1'b1);
                else mem_raddr = AW'(r_idx + 1'b1);
            end
            skvt_pkg::S_SHIFT_WR: begin
                mem_we = 1'b1;
                if (r_op == skvt_pkg::OP_WRITE) n_idx = r_idx - 1'b1;
                else n_idx = r_idx + 1'b1;
            end
            skvt_pkg::S_FINAL: begin
                mem_raddr = AW'(r_pos);
                if (r_op == skvt_pkg::OP_WRITE && r_out_st == skvt_pkg::ST_OK) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_pos);
                    mem_wkey  = r_key;
                    mem_wval  = r_val;
                    if (!r_found) n_count = r_count + 1'b1;
                end else if (r_op == skvt_pkg::OP_DELETE && r_found) begin
                    n_count = r_count - 1'b1;
                end
            end
            skvt_pkg::S_DONE: begin
                if (r_found && r_op != skvt_pkg::OP_WRITE
                        && r_op != skvt_pkg::OP_DELETE) begin
                    n_out_val = mem_rval;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skvt_pkg::S_IDLE;
            r_count <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_out_v <= (r_state == skvt_pkg::S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == skvt_pkg::S_IDLE && start) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_val <= i_value_in;
        end
        if (r_state == skvt_pkg::S_PROBE) r_mid <= mid_c;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_out_st  <= n_out_st;
        r_out_val <= n_out_val;
    end

    assign busy          = (r_state != skvt_pkg::S_IDLE);
    assign o_valid       = r_out_v;
    assign o_status      = r_out_st;
    assign o_value_out   = r_out_val;
    assign o_position    = skvt_pkg::POS_W'(r_pos);
    assign o_entry_count = skvt_pkg::POS_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count above capacity");
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == skvt_pkg::S_DONE)
        else $error("result without completion");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != skvt_pkg::S_FINAL |=> $stable(r_count))
        else $error("count changed outside final step");
    a_shift_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == skvt_pkg::S_SHIFT_RD |=> r_state == skvt_pkg::S_SHIFT_WR)
        else $error("shift read not followed by write");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

class table_scoreboard;
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [6:0]  position;
        logic [6:0]  count;
    } t_answer;

    logic signed [31:0] keys[64];
    logic signed [31:0] vals[64];
    int                 held;
    t_answer            pending[$];
    int                 errors;
    int                 checked;

    function new();
        held = 0;
        errors = 0;
        checked = 0;
    endfunction

    function void note_request(logic [1:0] op, logic signed [31:0] key,
                               logic signed [31:0] val);
        int lo;
        int hi;
        int mid;
        int pos;
        bit found;
        t_answer a;
        lo = 0;
        hi = held - 1;
        found = 0;
        pos = 0;
        while (lo <= hi && !found) begin
            mid = (lo + hi) / 2;
            if (key > keys[mid]) lo = mid + 1;
            else if (key < keys[mid]) hi = mid - 1;
            else begin
                found = 1;
                pos = mid;
            end
        end
        if (!found) pos = lo;
        a.value = '0;
        if (op == skvt_pkg::OP_WRITE) begin
            if (found) begin
                vals[pos] = val;
                a.status = skvt_pkg::ST_OK;
            end else if (held >= 64) begin
                a.status = skvt_pkg::ST_FULL;
            end else begin
                for (int i = held; i > pos; i--) begin
                    keys[i] = keys[i-1];
                    vals[i] = vals[i-1];
                end
                keys[pos] = key;
                vals[pos] = val;
                held++;
                a.status = skvt_pkg::ST_OK;
            end
        end else if (op == skvt_pkg::OP_DELETE) begin
            if (found) begin
                for (int i = pos; i + 1 < held; i++) begin
                    keys[i] = keys[i+1];
                    vals[i] = vals[i+1];
                end
                held--;
                a.status = skvt_pkg::ST_OK;
            end else a.status = skvt_pkg::ST_ABSENT;
        end else begin
            if (found) begin
                a.value = vals[pos];
                a.status = skvt_pkg::ST_OK;
            end else a.status = skvt_pkg::ST_ABSENT;
        end
        a.position = pos[6:0];
        a.count = held[6:0];
        pending.push_back(a);
    endfunction

    function void check_answer(logic [1:0] st, logic [31:0] v, logic [6:0] p,
                               logic [6:0] c);
        t_answer e;
        checked++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected answer status=%0d value=%h pos=%0d count=%0d",
                     $time, st, v, p, c);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
        end
        if (v !== e.value) begin
            $display("%0t: value expected %h actual %h", $time, e.value, v);
            errors++;
        end
        if (p !== e.position) begin
            $display("%0t: position expected %0d actual %0d", $time, e.position, p);
            errors++;
        end
        if (c !== e.count) begin
            $display("%0t: count expected %0d actual %0d", $time, e.count, c);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int WATCHDOG = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic signed [31:0] i_key;
    logic signed [31:0] i_value_in;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_value_out;
    logic [6:0]         o_position;
    logic [6:0]         o_entry_count;

    table_scoreboard    board;
    int                 idle_cycles;
    int                 sent;
    logic signed [31:0] pool[16];

    sorted_key_value_table DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_key(i_key), .i_value_in(i_value_in),
        .o_valid(o_valid), .o_status(o_status), .o_value_out(o_value_out),
        .o_position(o_position), .o_entry_count(o_entry_count)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_request(i_opcode, i_key, i_value_in);
                sent++;
            end
            if (o_valid)
                board.check_answer(o_status, o_value_out, o_position, o_entry_count);
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // holds start until the beat is taken, then idles a random gap
    task automatic issue(logic [1:0] op, logic signed [31:0] key,
                         logic signed [31:0] val);
        int gap;
        i_opcode <= op;
        i_key <= key;
        i_value_in <= val;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                          : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            i_opcode <= 2'($urandom);
            i_key <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_key(int mode);
        if (mode == 0) return pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    initial begin
        int op_sel;
        int mode;
        logic [1:0] op;
        board = new();
        idle_cycles = 0;
        sent = 0;
        start = 0;
        i_opcode = skvt_pkg::OP_LOOKUP;
        i_key = 0;
        i_value_in = 0;
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty table, extremes, spare opcode, missing deletes
        issue(skvt_pkg::OP_LOOKUP, 0, 0);
        issue(skvt_pkg::OP_DELETE, 5, 0);
        issue(skvt_pkg::OP_WRITE, 32'sh7fffffff, 32'sh80000000);
        issue(skvt_pkg::OP_WRITE, 32'sh80000000, 32'sh7fffffff);
        issue(skvt_pkg::OP_WRITE, 0, -1);
        issue(skvt_pkg::OP_WRITE, -1, 32'h55555555);
        issue(skvt_pkg::OP_LOOKUP, 32'sh80000000, 0);
        issue(skvt_pkg::OP_SPARE, 32'sh7fffffff, 0);
        issue(skvt_pkg::OP_WRITE, 0, 32'haaaaaaaa);
        issue(skvt_pkg::OP_LOOKUP, 0, 0);
        issue(skvt_pkg::OP_DELETE, 1, 0);
        issue(skvt_pkg::OP_DELETE, -1, 0);
        issue(skvt_pkg::OP_DELETE, 32'sh80000000, 0);
        issue(skvt_pkg::OP_LOOKUP, -1, 0);
        drain();

        // fill to capacity, then write more, replace at full, and empty again
        for (int i = 0; i < 70; i++)
            issue(skvt_pkg::OP_WRITE, $urandom, $urandom);
        issue(skvt_pkg::OP_WRITE, board.keys[10], 32'h12345678);
        issue(skvt_pkg::OP_LOOKUP, board.keys[10], 0);
        while (board.held > 0)
            issue(skvt_pkg::OP_DELETE, board.keys[$urandom_range(0, board.held - 1)], 0);
        drain();

        for (int i = 0; i < 16; i++) pool[i] = $urandom;
        pool[0] = 32'sh80000000;
        pool[1] = 32'sh7fffffff;
        for (int n = 0; n < 1800; n++) begin
            if (n % 300 == 0) begin
                drain();
                for (int i = 2; i < 16; i++) pool[i] = $urandom;
            end
            op_sel = $urandom_range(0, 99);
            mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
            // lean toward writes so the table fills up; odd phases add extra writes
            if (op_sel < 45) op = skvt_pkg::OP_WRITE;
            else if (op_sel < 70) op = skvt_pkg::OP_LOOKUP;
            else if (op_sel < 95) op = skvt_pkg::OP_DELETE;
            else op = skvt_pkg::OP_SPARE;
            if (mode == 0 && op != skvt_pkg::OP_WRITE && board.held > 0
                    && $urandom_range(0, 1))
                issue(op, board.keys[$urandom_range(0, board.held - 1)], $urandom);
            else
                issue(op, pick_key(mode), $urandom);
            if ((n / 300) % 2 == 1 && op_sel < 10)
                issue(skvt_pkg::OP_WRITE, $urandom, $urandom);
        end
        drain();
        repeat (200) @(negedge i_clk);

        $display("covered %0d requests, %0d answers checked, tables up to 64 entries",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
